@@ hdl/gbi_pkg.sv @@
// Shared constants for the grid bilinear interpolator.
// Used by gbi_divider and grid_bilinear_interpolator; no dependencies.
package gbi_pkg;

   // Command codes on req_cmd
   localparam logic [1:0] CMD_WR_STRIKE   = 2'd0;
   localparam logic [1:0] CMD_WR_MATURITY = 2'd1;
   localparam logic [1:0] CMD_WR_VALUE    = 2'd2;
   localparam logic [1:0] CMD_QUERY       = 2'd3;

   // Status codes on rsp_status
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_SATURATED  = 2'd1;
   localparam logic [1:0] ST_ZERO_WIDTH = 2'd2;

   // Fixed-point formats
   localparam int VAL_W  = 32;           // Q16.16 value width
   localparam int Q_FRAC = 16;           // fraction bits
   localparam int QUO_W  = VAL_W + Q_FRAC; // quotient of (num << 16) / den

   // Largest weight magnitude, 32768.0 in Q16.16
   localparam logic [QUO_W-1:0] WEIGHT_LIMIT = QUO_W'(64'h8000_0000);

endpackage

@@ hdl/gbi_divider.sv @@
// Restoring radix-2 divider: (dividend << 16) / divisor, one quotient bit a cycle.
// Depends on gbi_pkg for the operand and quotient widths.
module gbi_divider
   import gbi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] dividend,
   input  logic [VAL_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUO_W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0] div_ff, div_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [VAL_W:0]   trial;
   logic [VAL_W:0]   trial_sub;
   logic             take;

   // One trial subtraction per cycle
   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign take      = (trial >= {1'b0, div_ff});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         div_in = divisor;
         quo_in = {dividend, {Q_FRAC{1'b0}}};
      end else if (run_ff) begin
         rem_in = take ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], take};
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/grid_bilinear_interpolator.sv @@
// Top level: axis and table memories, query sequencer, shared divider and multiplier.
// Depends on gbi_pkg and gbi_divider.
//
//   channel   ports                                  handshake
//   request   req_cmd, req_*_index, req_strike,      start & !busy
//             req_maturity, req_grid_value
//   result    rsp_interpolated, rsp_status           rsp_valid, one cycle
//   config    psel penable pwrite paddr pwdata       psel&penable&pwrite
//             prdata pready                          (pready tied high)
//
// Writes complete while busy stays low.
// A query's time grows with the scan length on each axis (at most the point
// count); the two 48-step serial divisions dominate. A zero-width cell
// answers without starting any division.
// Reset is synchronous; axes and table hold garbage until written.
// The receiver cannot stall: each result word shows for one cycle.
module grid_bilinear_interpolator
   import gbi_pkg::*;
#(
   parameter int MAX_STRIKES    = 16,
   parameter int MAX_MATURITIES = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [3:0]         req_strike_index,
   input  logic [3:0]         req_maturity_index,
   input  logic [31:0]        req_strike,
   input  logic [31:0]        req_maturity,
   input  logic [31:0]        req_grid_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_interpolated,
   output logic [1:0]         rsp_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int MAXN = (MAX_STRIKES > MAX_MATURITIES) ? MAX_STRIKES : MAX_MATURITIES;
   localparam int SAW  = $clog2(MAX_STRIKES);
   localparam int MAW  = $clog2(MAX_MATURITIES);
   localparam int AW   = $clog2(MAXN);
   localparam int CW   = $clog2(MAXN + 1);
   localparam int TW   = $clog2(MAX_STRIKES * MAX_MATURITIES);

   localparam logic signed [50:0] ROW_MAX = 51'sd4294967295;
   localparam logic signed [50:0] ROW_MIN = -51'sd4294967295;
   localparam logic signed [50:0] OUT_MAX = 51'sd2147483647;
   localparam logic signed [50:0] OUT_MIN = -51'sd2147483648;

   // Sequencer states
   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_AX_LAST   = 5'd1;
   localparam logic [4:0] S_AX_FIRST  = 5'd2;
   localparam logic [4:0] S_AX_SCAN   = 5'd3;
   localparam logic [4:0] S_AX_K      = 5'd4;
   localparam logic [4:0] S_AX_LO     = 5'd5;
   localparam logic [4:0] S_AX_HI     = 5'd6;
   localparam logic [4:0] S_CHECK     = 5'd7;
   localparam logic [4:0] S_TB1       = 5'd8;
   localparam logic [4:0] S_TB2       = 5'd9;
   localparam logic [4:0] S_TB3       = 5'd10;
   localparam logic [4:0] S_TB4       = 5'd11;
   localparam logic [4:0] S_DIV_U     = 5'd12;
   localparam logic [4:0] S_DIV_S_GO  = 5'd13;
   localparam logic [4:0] S_DIV_S     = 5'd14;
   localparam logic [4:0] S_PREP      = 5'd15;
   localparam logic [4:0] S_MUL_LO    = 5'd16;
   localparam logic [4:0] S_MUL_HI    = 5'd17;
   localparam logic [4:0] S_MUL_END   = 5'd18;

   // Blend passes
   localparam logic [1:0] BL_ROW1  = 2'd0;
   localparam logic [1:0] BL_ROW2  = 2'd1;
   localparam logic [1:0] BL_FINAL = 2'd2;

   function automatic logic [TW-1:0] tb_index(input logic [AW-1:0] t, input logic [AW-1:0] k);
      tb_index = TW'(TW'(t) * TW'(MAX_STRIKES) + TW'(k));
   endfunction

   // ---------------- configuration registers ----------------
   logic [4:0] strike_count_ff, strike_count_in;
   logic [4:0] maturity_count_ff, maturity_count_in;
   logic       cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_comb begin
      strike_count_in   = strike_count_ff;
      maturity_count_in = maturity_count_ff;
      if (cfg_wr) begin
         if (paddr[2]) maturity_count_in = pwdata[4:0];
         else          strike_count_in   = pwdata[4:0];
      end
   end

   assign prdata = paddr[2] ? {27'd0, maturity_count_ff} : {27'd0, strike_count_ff};

   // Points in use, clamped to [2, max]
   logic [CW-1:0] nk, nt;
   always_comb begin
      if (strike_count_ff < 5'd2)               nk = CW'(2);
      else if (strike_count_ff > MAX_STRIKES)   nk = CW'(MAX_STRIKES);
      else                                      nk = CW'(strike_count_ff);
      if (maturity_count_ff < 5'd2)             nt = CW'(2);
      else if (maturity_count_ff > MAX_MATURITIES) nt = CW'(MAX_MATURITIES);
      else                                      nt = CW'(maturity_count_ff);
   end

   // ---------------- sequencer registers ----------------
   logic [4:0]        state_ff, state_in;
   logic              sel_ff, sel_in;          // 0 strike axis, 1 maturity axis
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     lb_ff, lb_in;
   logic [31:0]       first_ff, first_in, last_ff, last_in;
   logic [AW-1:0]     k1_ff, k1_in, t1_ff, t1_in;
   logic [31:0]       klo_ff, klo_in, khi_ff, khi_in, tlo_ff, tlo_in, thi_ff, thi_in;
   logic [31:0]       x_ff, x_in, y_ff, y_in;
   logic [31:0]       v11_ff, v11_in, v12_ff, v12_in, v21_ff, v21_in, v22_ff, v22_in;
   logic              u_neg_ff, u_neg_in, s_neg_ff, s_neg_in;
   logic [31:0]       u_mag_ff, u_mag_in, s_mag_ff, s_mag_in;
   logic              sat_ff, sat_in;
   logic [1:0]        bl_ff, bl_in;
   logic [32:0]       a_mag_ff, a_mag_in;
   logic [31:0]       w_mag_ff, w_mag_in;
   logic              p_neg_ff, p_neg_in;
   logic signed [33:0] base_ff, base_in;
   logic [64:0]       acc_ff, acc_in;
   logic signed [33:0] r1_ff, r1_in, r2_ff, r2_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   logic [1:0]        rsp_st_ff, rsp_st_in;

   // ---------------- memories ----------------
   logic [31:0] strike_mem [MAX_STRIKES];
   logic [31:0] maturity_mem [MAX_MATURITIES];
   logic [31:0] value_mem [MAX_STRIKES * MAX_MATURITIES];
   logic [31:0] sk_rd_ff, mt_rd_ff, tb_rd_ff;
   logic [AW-1:0] ax_addr;
   logic [TW-1:0] tb_addr;
   logic          accept;

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_WR_STRIKE && req_strike_index < MAX_STRIKES) begin
         strike_mem[SAW'(req_strike_index)] <= req_strike;
      end
      sk_rd_ff <= strike_mem[ax_addr[SAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_WR_MATURITY && req_maturity_index < MAX_MATURITIES) begin
         maturity_mem[MAW'(req_maturity_index)] <= req_maturity;
      end
      mt_rd_ff <= maturity_mem[ax_addr[MAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_WR_VALUE && req_strike_index < MAX_STRIKES
          && req_maturity_index < MAX_MATURITIES) begin
         value_mem[TW'(TW'(req_maturity_index) * TW'(MAX_STRIKES)
                   + TW'(req_strike_index))] <= req_grid_value;
      end
      tb_rd_ff <= value_mem[tb_addr];
   end

   // ---------------- shared divider ----------------
   logic              div_start, div_done;
   logic [QUO_W-1:0]  div_quo;
   logic              frac_s;
   logic [31:0]       fr_pt, fr_lo, fr_hi;
   logic signed [32:0] fr_num, fr_den;
   logic              fr_neg;
   logic [31:0]       num_mag, den_mag;
   logic [31:0]       w_clamped;
   logic              w_over;

   assign frac_s  = (state_ff == S_DIV_S_GO) || (state_ff == S_DIV_S);
   assign fr_pt   = frac_s ? y_ff : x_ff;
   assign fr_lo   = frac_s ? tlo_ff : klo_ff;
   assign fr_hi   = frac_s ? thi_ff : khi_ff;
   assign fr_num  = $signed({1'b0, fr_pt}) - $signed({1'b0, fr_lo});
   assign fr_den  = $signed({1'b0, fr_hi}) - $signed({1'b0, fr_lo});
   assign fr_neg  = fr_num[32] ^ fr_den[32];
   assign num_mag = fr_num[32] ? 32'(-fr_num) : fr_num[31:0];
   assign den_mag = fr_den[32] ? 32'(-fr_den) : fr_den[31:0];
   assign w_over  = (div_quo > WEIGHT_LIMIT);
   assign w_clamped = w_over ? WEIGHT_LIMIT[31:0] : div_quo[31:0];

   gbi_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_mag),
      .divisor  (den_mag),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------- axis search helpers ----------------
   logic [CW-1:0] n_cur;
   logic [31:0]   q_cur, ax_rd;
   logic [AW-1:0] k_sel, k_cur;

   assign n_cur = sel_ff ? nt : nk;
   assign q_cur = sel_ff ? y_ff : x_ff;
   assign ax_rd = sel_ff ? mt_rd_ff : sk_rd_ff;
   assign k_cur = sel_ff ? t1_ff : k1_ff;

   // Clamp to the first or last cell; the last-cell check wins
   always_comb begin
      if (q_cur >= last_ff)       k_sel = AW'(n_cur - CW'(2));
      else if (q_cur <= first_ff) k_sel = '0;
      else                        k_sel = AW'(lb_ff - CW'(1));
   end

   // ---------------- blend datapath ----------------
   logic signed [34:0] diff_sel;
   logic signed [33:0] base_sel;
   logic [31:0]        wsel_mag;
   logic               wsel_neg;
   logic [15:0]        mul_b;
   logic [48:0]        mul_p;
   logic [48:0]        blend_m;
   logic signed [50:0] blend_sum;

   always_comb begin
      case (bl_ff)
         BL_ROW1: begin
            diff_sel = $signed({3'b000, v12_ff}) - $signed({3'b000, v11_ff});
            base_sel = $signed({2'b00, v11_ff});
         end
         BL_ROW2: begin
            diff_sel = $signed({3'b000, v22_ff}) - $signed({3'b000, v21_ff});
            base_sel = $signed({2'b00, v21_ff});
         end
         default: begin
            diff_sel = $signed({r2_ff[33], r2_ff}) - $signed({r1_ff[33], r1_ff});
            base_sel = r1_ff;
         end
      endcase
      wsel_mag = (bl_ff == BL_FINAL) ? s_mag_ff : u_mag_ff;
      wsel_neg = (bl_ff == BL_FINAL) ? s_neg_ff : u_neg_ff;
   end

   // One 33x16 multiplier, used for the low then the high half of the weight
   assign mul_b     = (state_ff == S_MUL_HI) ? w_mag_ff[31:16] : w_mag_ff[15:0];
   assign mul_p     = a_mag_ff * mul_b;
   assign blend_m   = acc_ff[64:16];
   assign blend_sum = p_neg_ff
                      ? ($signed({{17{base_ff[33]}}, base_ff}) - $signed({2'b00, blend_m}))
                      : ($signed({{17{base_ff[33]}}, base_ff}) + $signed({2'b00, blend_m}));

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      lb_in        = lb_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      k1_in        = k1_ff;
      t1_in        = t1_ff;
      klo_in       = klo_ff;
      khi_in       = khi_ff;
      tlo_in       = tlo_ff;
      thi_in       = thi_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      v11_in       = v11_ff;
      v12_in       = v12_ff;
      v21_in       = v21_ff;
      v22_in       = v22_ff;
      u_neg_in     = u_neg_ff;
      u_mag_in     = u_mag_ff;
      s_neg_in     = s_neg_ff;
      s_mag_in     = s_mag_ff;
      sat_in       = sat_ff;
      bl_in        = bl_ff;
      a_mag_in     = a_mag_ff;
      w_mag_in     = w_mag_ff;
      p_neg_in     = p_neg_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      rsp_valid_in = 1'b0;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      ax_addr      = '0;
      tb_addr      = tb_index(t1_ff, k1_ff);
      div_start    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start && req_cmd == CMD_QUERY) begin
               x_in     = req_strike;
               y_in     = req_maturity;
               sat_in   = 1'b0;
               sel_in   = 1'b0;
               state_in = S_AX_LAST;
            end
         end
         // Fetch the last used point, then scan from the first
         S_AX_LAST: begin
            ax_addr  = AW'(n_cur - CW'(1));
            state_in = S_AX_FIRST;
         end
         S_AX_FIRST: begin
            last_in  = ax_rd;
            ax_addr  = '0;
            idx_in   = '0;
            state_in = S_AX_SCAN;
         end
         // Lower bound: first point not below the query
         S_AX_SCAN: begin
            if (idx_ff == '0) first_in = ax_rd;
            if (ax_rd >= q_cur) begin
               lb_in    = idx_ff;
               state_in = S_AX_K;
            end else if (CW'(idx_ff + 1'b1) == n_cur) begin
               lb_in    = n_cur;
               state_in = S_AX_K;
            end else begin
               idx_in   = CW'(idx_ff + 1'b1);
               ax_addr  = AW'(idx_ff + 1'b1);
            end
         end
         S_AX_K: begin
            ax_addr = k_sel;
            if (sel_ff) t1_in = k_sel;
            else        k1_in = k_sel;
            state_in = S_AX_LO;
         end
         S_AX_LO: begin
            if (sel_ff) tlo_in = ax_rd;
            else        klo_in = ax_rd;
            ax_addr  = AW'(k_cur + 1'b1);
            state_in = S_AX_HI;
         end
         S_AX_HI: begin
            if (sel_ff) begin
               thi_in   = ax_rd;
               state_in = S_CHECK;
            end else begin
               khi_in   = ax_rd;
               sel_in   = 1'b1;
               state_in = S_AX_LAST;
            end
         end
         // Zero-width cell answers at once; otherwise start u and read corners
         S_CHECK: begin
            if (klo_ff == khi_ff || tlo_ff == thi_ff) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = '0;
               rsp_st_in    = ST_ZERO_WIDTH;
               state_in     = S_IDLE;
            end else begin
               tb_addr   = tb_index(t1_ff, k1_ff);
               div_start = 1'b1;
               state_in  = S_TB1;
            end
         end
         S_TB1: begin
            v11_in   = tb_rd_ff;
            tb_addr  = tb_index(t1_ff, AW'(k1_ff + 1'b1));
            state_in = S_TB2;
         end
         S_TB2: begin
            v12_in   = tb_rd_ff;
            tb_addr  = tb_index(AW'(t1_ff + 1'b1), k1_ff);
            state_in = S_TB3;
         end
         S_TB3: begin
            v21_in   = tb_rd_ff;
            tb_addr  = tb_index(AW'(t1_ff + 1'b1), AW'(k1_ff + 1'b1));
            state_in = S_TB4;
         end
         S_TB4: begin
            v22_in   = tb_rd_ff;
            state_in = S_DIV_U;
         end
         S_DIV_U: begin
            if (div_done) begin
               u_mag_in = w_clamped;
               u_neg_in = fr_neg;
               if (w_over) sat_in = 1'b1;
               state_in = S_DIV_S_GO;
            end
         end
         S_DIV_S_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_S;
         end
         S_DIV_S: begin
            if (div_done) begin
               s_mag_in = w_clamped;
               s_neg_in = fr_neg;
               if (w_over) sat_in = 1'b1;
               bl_in    = BL_ROW1;
               state_in = S_PREP;
            end
         end
         // Blend: base +- (|diff| * |w|) >> 16
         S_PREP: begin
            a_mag_in = diff_sel[34] ? 33'(-diff_sel) : diff_sel[32:0];
            p_neg_in = diff_sel[34] ^ wsel_neg;
            w_mag_in = wsel_mag;
            base_in  = base_sel;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            acc_in   = {16'd0, mul_p};
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            acc_in   = 65'(acc_ff + {mul_p, 16'd0});
            state_in = S_MUL_END;
         end
         S_MUL_END: begin
            if (bl_ff == BL_FINAL) begin
               rsp_valid_in = 1'b1;
               if (blend_sum > OUT_MAX) begin
                  rsp_val_in = 32'sh7FFF_FFFF;
                  rsp_st_in  = ST_SATURATED;
               end else if (blend_sum < OUT_MIN) begin
                  rsp_val_in = 32'sh8000_0000;
                  rsp_st_in  = ST_SATURATED;
               end else begin
                  rsp_val_in = blend_sum[31:0];
                  rsp_st_in  = sat_ff ? ST_SATURATED : ST_OK;
               end
               state_in = S_IDLE;
            end else begin
               // Row clamp to +-(2^32-1)
               if (blend_sum > ROW_MAX) begin
                  base_in = ROW_MAX[33:0];
                  sat_in  = 1'b1;
               end else if (blend_sum < ROW_MIN) begin
                  base_in = ROW_MIN[33:0];
                  sat_in  = 1'b1;
               end else begin
                  base_in = blend_sum[33:0];
               end
               if (bl_ff == BL_ROW1) r1_in = base_in;
               else                  r2_in = base_in;
               bl_in    = 2'(bl_ff + 1'b1);
               state_in = S_PREP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         strike_count_ff   <= 5'd2;
         maturity_count_ff <= 5'd2;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         strike_count_ff   <= strike_count_in;
         maturity_count_ff <= maturity_count_in;
      end
      sel_ff     <= sel_in;
      idx_ff     <= idx_in;
      lb_ff      <= lb_in;
      first_ff   <= first_in;
      last_ff    <= last_in;
      k1_ff      <= k1_in;
      t1_ff      <= t1_in;
      klo_ff     <= klo_in;
      khi_ff     <= khi_in;
      tlo_ff     <= tlo_in;
      thi_ff     <= thi_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      v11_ff     <= v11_in;
      v12_ff     <= v12_in;
      v21_ff     <= v21_in;
      v22_ff     <= v22_in;
      u_neg_ff   <= u_neg_in;
      u_mag_ff   <= u_mag_in;
      s_neg_ff   <= s_neg_in;
      s_mag_ff   <= s_mag_in;
      sat_ff     <= sat_in;
      bl_ff      <= bl_in;
      a_mag_ff   <= a_mag_in;
      w_mag_ff   <= w_mag_in;
      p_neg_ff   <= p_neg_in;
      base_ff    <= base_in;
      acc_ff     <= acc_in;
      r1_ff      <= r1_in;
      r2_ff      <= r2_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interpolated = rsp_val_ff;
   assign rsp_status       = rsp_st_ff;

   // ---------------- assertions ----------------
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer busy");

   a_write_single: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd != CMD_QUERY) |=> !busy)
      else $error("write word did not complete in one cycle");

   a_zero_width: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ZERO_WIDTH) |-> (rsp_interpolated == 32'sd0))
      else $error("zero-width cell with nonzero result");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

endmodule
